### rtl/data_eeprom_register_controller_unit_defines.svh
// Assertion macros for the data EEPROM register controller.
`ifndef DATA_EEPROM_REGISTER_CONTROLLER_UNIT_DEFINES_SVH
`define DATA_EEPROM_REGISTER_CONTROLLER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/deerc_pkg.sv
`timescale 1ns / 1ps

package deerc_pkg;

   localparam int ARRAY_DEPTH_DEF = 256;
   localparam int DURATION_W      = 16;
   localparam logic [DURATION_W-1:0] DURATION_RESET = 16'd4;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam logic CSR_IDX_DURATION = 1'b0;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_WRITE = 2'd2;
   localparam logic [1:0] ACT_ABORT = 2'd3;

   localparam logic [2:0] SEL_ADDR   = 3'd0;
   localparam logic [2:0] SEL_DATA   = 3'd1;
   localparam logic [2:0] SEL_CTRL   = 3'd2;
   localparam logic [2:0] SEL_UNLOCK = 3'd3;
   localparam logic [2:0] SEL_DONE   = 3'd4;

   localparam logic [7:0] UNLOCK_KEY1 = 8'h55;
   localparam logic [7:0] UNLOCK_KEY2 = 8'hAA;

   localparam logic [1:0] STAGE_IDLE  = 2'd0;
   localparam logic [1:0] STAGE_FIRST = 2'd1;
   localparam logic [1:0] STAGE_ARMED = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] register_select;
      logic [7:0] bus_write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       write_busy;
      logic       done_flag;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic mem_load;
   } cmd_type;

   typedef struct packed {
      logic load_req;
   } status_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_LOAD
   } ctrl_state_type;

endpackage

### rtl/data_eeprom_register_controller_unit.sv
// Data EEPROM register controller: a byte array behind address, data, control, unlock and
// done-flag registers, driven by one bus transaction per item (tick, read, write, abort).
// Every transaction yields one response from an output register. A control write that fires
// the read strobe blocks the next transaction while the data register is loaded in the
// following cycle, since the cell array is a RAM with a registered read port. Otherwise a new
// transaction is taken when the output register is empty or being drained. Erased cells read
// 0xFF through per-cell valid flags cleared by reset, so no clearing pass is needed. The
// write duration register sits at byte addresses 0 to 3 of the configuration port.
`timescale 1ns / 1ps
`include "data_eeprom_register_controller_unit_defines.svh"

module data_eeprom_register_controller_unit #(
   parameter int ARRAY_DEPTH = deerc_pkg::ARRAY_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  deerc_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output deerc_pkg::rsp_type                rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [deerc_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [deerc_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [deerc_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);

   logic [deerc_pkg::DURATION_W-1:0] write_duration;
   deerc_pkg::cmd_type               ctrl_cmd;
   deerc_pkg::status_type            dp_status;

   deerc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .write_duration (write_duration)
   );

   deerc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .cmd       (ctrl_cmd)
   );

   deerc_dpath #(
      .ARRAY_DEPTH (ARRAY_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctrl_cmd),
      .status         (dp_status),
      .req_data       (req_data),
      .write_duration (write_duration),
      .rsp_data       (rsp_data)
   );

   `ASSERT_NEXT(a_load_follows_strobe, clock, reset, ctrl_cmd.accept && dp_status.load_req, ctrl_cmd.mem_load)
   `ASSERT_IMPLIES(a_load_blocks_input, clock, reset, ctrl_cmd.mem_load, req_stall && rsp_valid)
   `ASSERT_IMPLIES(a_rsp_from_accept, clock, reset, $rose(rsp_valid), $past(ctrl_cmd.accept))

endmodule

### rtl/deerc_ram.sv
`timescale 1ns / 1ps

module deerc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/deerc_csr.sv
`timescale 1ns / 1ps

module deerc_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [deerc_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [deerc_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [deerc_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                   pready,
   output logic [deerc_pkg::DURATION_W-1:0]       write_duration
);

   logic [deerc_pkg::DURATION_W-1:0] duration_ff;
   logic [deerc_pkg::DURATION_W-1:0] duration_in;
   logic                             sel_duration;

   assign sel_duration = (paddr[deerc_pkg::CSR_ADDR_W-1] == deerc_pkg::CSR_IDX_DURATION);

   always_comb begin
      duration_in = duration_ff;
      if (psel && penable && pwrite && sel_duration) begin
         duration_in = pwdata[deerc_pkg::DURATION_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= deerc_pkg::DURATION_RESET;
      end else begin
         duration_ff <= duration_in;
      end
   end

   assign prdata = sel_duration
      ? {{(deerc_pkg::CSR_DATA_W - deerc_pkg::DURATION_W){1'b0}}, duration_ff}
      : '0;
   assign pready = 1'b1;
   assign write_duration = duration_ff;

endmodule

### rtl/deerc_ctrl.sv
`timescale 1ns / 1ps

module deerc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  deerc_pkg::status_type   status,
   output deerc_pkg::cmd_type      cmd
);

   deerc_pkg::ctrl_state_type state_ff;
   deerc_pkg::ctrl_state_type state_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      can_take;

   always_comb begin
      state_in     = state_ff;
      can_take     = 1'b0;
      cmd.accept   = 1'b0;
      cmd.mem_load = 1'b0;
      case (state_ff)
         deerc_pkg::ST_IDLE: begin
            can_take   = !rsp_valid_ff || !rsp_stall;
            cmd.accept = req_valid && can_take;
            if (cmd.accept && status.load_req) begin
               state_in = deerc_pkg::ST_LOAD;
            end
         end
         deerc_pkg::ST_LOAD: begin
            cmd.mem_load = 1'b1;
            state_in     = deerc_pkg::ST_IDLE;
         end
         default: begin
            state_in = deerc_pkg::ST_IDLE;
         end
      endcase

      if (cmd.accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deerc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !can_take;
   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/deerc_dpath.sv
`timescale 1ns / 1ps

module deerc_dpath #(
   parameter int ARRAY_DEPTH = deerc_pkg::ARRAY_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  deerc_pkg::cmd_type                 cmd,
   output deerc_pkg::status_type              status,
   input  deerc_pkg::req_type                 req_data,
   input  logic [deerc_pkg::DURATION_W-1:0]   write_duration,
   output deerc_pkg::rsp_type                 rsp_data
);

   localparam int IDX_W = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;
   localparam logic [8:0] ADDR_LIMIT = 9'(ARRAY_DEPTH);
   localparam int CTL_RD    = 0;
   localparam int CTL_WR    = 1;
   localparam int CTL_WREN  = 2;
   localparam int CTL_WRERR = 3;

   logic [7:0]                     address_ff, address_in;
   logic [7:0]                     data_ff, data_in;
   logic [1:0]                     space_ff, space_in;
   logic                           wr_en_ff, wr_en_in;
   logic                           active_ff, active_in;
   logic                           error_ff, error_in;
   logic [1:0]                     stage_ff, stage_in;
   logic                           done_ff, done_in;
   logic [deerc_pkg::DURATION_W-1:0] count_ff, count_in;
   logic [7:0]                     pend_addr_ff, pend_addr_in;
   logic [7:0]                     pend_byte_ff, pend_byte_in;
   logic [ARRAY_DEPTH-1:0]         cell_valid_ff, cell_valid_in;
   logic                           hit_ff, hit_in;
   logic                           start_load_ff, start_load_in;
   deerc_pkg::rsp_type             rsp_ff, rsp_in;

   logic [7:0]       wbyte;
   logic             is_ctl_wr;
   logic             start_ok;
   logic             addr_ok;
   logic             pend_ok;
   logic [IDX_W-1:0] addr_idx;
   logic [IDX_W-1:0] pend_idx;
   logic [7:0]       rd;
   logic [7:0]       load_byte;
   logic             ram_we;
   logic             ram_re;
   logic [7:0]       ram_rdata;

   assign wbyte     = req_data.bus_write_data;
   assign addr_idx  = address_ff[IDX_W-1:0];
   assign pend_idx  = pend_addr_ff[IDX_W-1:0];
   assign addr_ok   = {1'b0, address_ff} < ADDR_LIMIT;
   assign pend_ok   = {1'b0, pend_addr_ff} < ADDR_LIMIT;
   assign is_ctl_wr = (req_data.action == deerc_pkg::ACT_WRITE)
                   && (req_data.register_select == deerc_pkg::SEL_CTRL);
   assign status.load_req = is_ctl_wr && wbyte[CTL_RD] && (wbyte[7:6] == 2'b00);
   assign start_ok  = is_ctl_wr && wbyte[CTL_WR] && (wbyte[7:6] == 2'b00) && wr_en_ff
                   && (stage_ff == deerc_pkg::STAGE_ARMED) && !active_ff;
   assign load_byte = hit_ff ? ram_rdata : 8'hFF;

   always_comb begin
      address_in    = address_ff;
      data_in       = data_ff;
      space_in      = space_ff;
      wr_en_in      = wr_en_ff;
      active_in     = active_ff;
      error_in      = error_ff;
      stage_in      = stage_ff;
      done_in       = done_ff;
      count_in      = count_ff;
      pend_addr_in  = pend_addr_ff;
      pend_byte_in  = pend_byte_ff;
      cell_valid_in = cell_valid_ff;
      start_load_in = start_load_ff;
      hit_in        = hit_ff;
      rd            = 8'h00;
      ram_we        = 1'b0;
      ram_re        = 1'b0;

      if (cmd.accept) begin
         start_load_in = start_ok;
         case (req_data.action)
            deerc_pkg::ACT_TICK: begin
               if (active_ff) begin
                  if (count_ff > 16'd1) begin
                     count_in = count_ff - 16'd1;
                  end else begin
                     count_in  = '0;
                     active_in = 1'b0;
                     done_in   = 1'b1;
                     if (pend_ok) begin
                        ram_we                  = 1'b1;
                        cell_valid_in[pend_idx] = 1'b1;
                     end
                  end
               end
            end
            deerc_pkg::ACT_READ: begin
               case (req_data.register_select)
                  deerc_pkg::SEL_ADDR: rd = address_ff;
                  deerc_pkg::SEL_DATA: rd = data_ff;
                  deerc_pkg::SEL_CTRL: rd = {space_ff, 2'b00, error_ff, wr_en_ff, active_ff, 1'b0};
                  deerc_pkg::SEL_DONE: rd = {7'd0, done_ff};
                  default:             rd = 8'h00;
               endcase
               stage_in = deerc_pkg::STAGE_IDLE;
            end
            deerc_pkg::ACT_WRITE: begin
               stage_in = deerc_pkg::STAGE_IDLE;
               case (req_data.register_select)
                  deerc_pkg::SEL_UNLOCK: begin
                     if (wbyte == deerc_pkg::UNLOCK_KEY1) begin
                        stage_in = deerc_pkg::STAGE_FIRST;
                     end else if (wbyte == deerc_pkg::UNLOCK_KEY2
                                  && stage_ff == deerc_pkg::STAGE_FIRST) begin
                        stage_in = deerc_pkg::STAGE_ARMED;
                     end
                  end
                  deerc_pkg::SEL_ADDR: address_in = wbyte;
                  deerc_pkg::SEL_DATA: data_in = wbyte;
                  deerc_pkg::SEL_CTRL: begin
                     space_in = wbyte[7:6];
                     error_in = wbyte[CTL_WRERR];
                     wr_en_in = wbyte[CTL_WREN];
                     if (status.load_req) begin
                        ram_re = 1'b1;
                        hit_in = addr_ok && cell_valid_ff[addr_idx];
                     end
                     if (start_ok) begin
                        active_in    = 1'b1;
                        pend_addr_in = address_ff;
                        pend_byte_in = data_ff;
                        count_in     = (write_duration == '0) ? 16'd1 : write_duration;
                     end
                  end
                  deerc_pkg::SEL_DONE: done_in = wbyte[0];
                  default: begin
                  end
               endcase
            end
            deerc_pkg::ACT_ABORT: begin
               if (active_ff) begin
                  active_in = 1'b0;
                  count_in  = '0;
                  error_in  = 1'b1;
               end
               stage_in = deerc_pkg::STAGE_IDLE;
            end
            default: begin
            end
         endcase
      end

      // read strobe data lands in the cycle after the transaction
      if (cmd.mem_load) begin
         data_in = load_byte;
         if (start_load_ff) begin
            pend_byte_in = load_byte;
         end
      end

      rsp_in.read_data  = rd;
      rsp_in.write_busy = active_in;
      rsp_in.done_flag  = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         address_ff    <= '0;
         data_ff       <= '0;
         space_ff      <= '0;
         wr_en_ff      <= 1'b0;
         active_ff     <= 1'b0;
         error_ff      <= 1'b0;
         stage_ff      <= deerc_pkg::STAGE_IDLE;
         done_ff       <= 1'b0;
         count_ff      <= '0;
         pend_addr_ff  <= '0;
         pend_byte_ff  <= '0;
         cell_valid_ff <= '0;
         start_load_ff <= 1'b0;
      end else begin
         address_ff    <= address_in;
         data_ff       <= data_in;
         space_ff      <= space_in;
         wr_en_ff      <= wr_en_in;
         active_ff     <= active_in;
         error_ff      <= error_in;
         stage_ff      <= stage_in;
         done_ff       <= done_in;
         count_ff      <= count_in;
         pend_addr_ff  <= pend_addr_in;
         pend_byte_ff  <= pend_byte_in;
         cell_valid_ff <= cell_valid_in;
         start_load_ff <= start_load_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (cmd.accept) begin
         rsp_ff <= rsp_in;
      end
   end

   deerc_ram #(
      .WIDTH (8),
      .DEPTH (ARRAY_DEPTH)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (pend_idx),
      .wdata (pend_byte_ff),
      .re    (ram_re),
      .raddr (addr_idx),
      .rdata (ram_rdata)
   );

   assign rsp_data = rsp_ff;

endmodule
